// ===== sv/ddrmp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddrmp_pkg
// Shared types and constants for the differential drive ramp mixer and
// motor packetizer.
// ----------------------------------------------------------------------------
package ddrmp_pkg;

  // Default structural parameters
  localparam int SPEED_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 12;

  // Fixed field widths
  localparam int TGT_W       = 16;
  localparam int LIMIT_W     = 15;
  localparam int SCALE_W     = 16;
  localparam int ADDR_W      = 8;
  localparam int CODE_W      = 3;
  localparam int DATA_W      = 7;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam int PKTS_PER_ITEM = 4;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MAX_LINEAR_RST    = 15'd4096;
  localparam logic [LIMIT_W-1:0] MAX_ANGULAR_RST   = 15'd8192;
  localparam logic [LIMIT_W-1:0] RAMP_STEP_RST     = 15'd205;
  localparam logic [LIMIT_W-1:0] HALF_TRACK_RST    = 15'd1024;
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST   = 16'd32512;
  localparam logic [ADDR_W-1:0]  FRONT_ADDRESS_RST = 8'd128;
  localparam logic [ADDR_W-1:0]  REAR_ADDRESS_RST  = 8'd129;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_LINEAR    = 3'd0,
    REG_MAX_ANGULAR   = 3'd1,
    REG_RAMP_STEP     = 3'd2,
    REG_HALF_TRACK    = 3'd3,
    REG_SPEED_SCALE   = 3'd4,
    REG_FRONT_ADDRESS = 3'd5,
    REG_REAR_ADDRESS  = 3'd6
  } reg_index_t;

  // Item function codes
  localparam logic FUNC_DRIVE = 1'b0;
  localparam logic FUNC_STOP  = 1'b1;

  // Packet command codes
  localparam logic [CODE_W-1:0] CODE_M1_FWD  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_M1_BACK = 3'd1;
  localparam logic [CODE_W-1:0] CODE_M2_FWD  = 3'd4;
  localparam logic [CODE_W-1:0] CODE_M2_BACK = 3'd5;

  localparam logic [DATA_W-1:0] DATA_MAX = 7'h7F;

  typedef struct packed {
    logic                    func;
    logic signed [TGT_W-1:0] linear_setpoint;
    logic signed [TGT_W-1:0] angular_setpoint;
  } drive_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] packet_address;
    logic [CODE_W-1:0] command_code;
    logic [DATA_W-1:0] data_byte;
    logic [DATA_W-1:0] checksum_byte;
    logic              last_packet;
  } motor_packet_t;

  // One side's motor command: direction and magnitude
  typedef struct packed {
    logic              back;
    logic [DATA_W-1:0] mag;
  } motor_cmd_t;

endpackage

// ===== sv/ddrmp_serial_mult.sv =====
// ----------------------------------------------------------------------------
// ddrmp_serial_mult
// Unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddrmp_serial_mult #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     multiplicand,
  input  logic [B_W-1:0]     multiplier,
  output logic               busy,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W+B_W-1:0] acc;
  logic [A_W-1:0]     a_q;
  logic [CNT_W-1:0]   cnt;
  logic [A_W:0]       partial;

  // Upper half accumulates, lower half shifts out multiplier bits
  assign partial = {1'b0, acc[A_W+B_W-1:B_W]} + (acc[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(B_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {{A_W{1'b0}}, multiplier};
      a_q <= multiplicand;
    end else if (cnt != '0) begin
      acc <= {partial, acc[B_W-1:1]};
    end
  end

  assign busy    = (cnt != '0);
  assign product = acc;

endmodule

// ===== sv/ddrmp_pkt_out.sv =====
// ----------------------------------------------------------------------------
// ddrmp_pkt_out
// Sequences the four motor packets of one item into an output register.
// ----------------------------------------------------------------------------
module ddrmp_pkt_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  ddrmp_pkg::motor_cmd_t        left,
  input  ddrmp_pkg::motor_cmd_t        right,
  input  logic [ddrmp_pkg::ADDR_W-1:0] front_address,
  input  logic [ddrmp_pkg::ADDR_W-1:0] rear_address,
  output logic                         busy,
  output logic                         pkt_valid,
  input  logic                         pkt_ready,
  output ddrmp_pkg::motor_packet_t     pkt
);

  localparam logic [1:0] LAST_IDX = 2'(ddrmp_pkg::PKTS_PER_ITEM - 1);

  logic                           active;
  logic [1:0]                     idx;
  logic                           load;
  ddrmp_pkg::motor_cmd_t          sel;
  logic [ddrmp_pkg::ADDR_W-1:0]   addr;
  logic [ddrmp_pkg::CODE_W-1:0]   code;
  ddrmp_pkg::motor_packet_t       pkt_next;

  assign load = active && (!pkt_valid || pkt_ready);

  // Even packets carry the left side on motor 1, odd the right on motor 2
  always_comb begin
    sel  = idx[0] ? right : left;
    addr = idx[1] ? rear_address : front_address;
    if (idx[0]) begin
      code = sel.back ? ddrmp_pkg::CODE_M2_BACK : ddrmp_pkg::CODE_M2_FWD;
    end else begin
      code = sel.back ? ddrmp_pkg::CODE_M1_BACK : ddrmp_pkg::CODE_M1_FWD;
    end
    pkt_next.packet_address = addr;
    pkt_next.command_code   = code;
    pkt_next.data_byte      = sel.mag;
    pkt_next.checksum_byte  = addr[ddrmp_pkg::DATA_W-1:0]
                              + ddrmp_pkg::DATA_W'(code) + sel.mag;
    pkt_next.last_packet    = (idx == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      pkt_valid <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (load) begin
        idx <= idx + 1'b1;
        if (idx == LAST_IDX) begin
          active <= 1'b0;
        end
      end
      if (load) begin
        pkt_valid <= 1'b1;
      end else if (pkt_ready) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt <= pkt_next;
    end
  end

  assign busy = active;

endmodule

// ===== sv/diff_drive_ramp_mixer_packetizer.sv =====
// ----------------------------------------------------------------------------
// diff_drive_ramp_mixer_packetizer
// Differential drive mixer with slew-rate limit and motor packet output.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one drive or stop item per
//   transfer; cmd_ready is high only while the block is idle.
//   pkt channel (pkt_valid/pkt_ready/pkt) gives four packets per item: front
//   motor 1, front motor 2, rear motor 1, rear motor 2; last_packet marks
//   the fourth.
//   cfg_write/cfg_index/cfg_data write a register; write only
//   while idle. Indexes past the register list are dropped.
// Sequencing (MAG_W = SPEED_WIDTH + max(FRAC_BITS, 15), 31 by default):
//   drive item: the speeds ramp, then the 15-step half-track multiply and
//   the MAG_W-step scale multiplies, one bit a cycle, run before the first
//   packet. No new item is taken while one is in progress.
//   stop item: zero commands go straight to the packet output with no
//   multiply.
// Reset clears the stored speeds, loads register defaults and empties the
// output register. A stalled receiver holds the current packet; the block
// waits before loading the next, and takes a new item once the fourth
// packet sits in the output register.
// ----------------------------------------------------------------------------
module diff_drive_ramp_mixer_packetizer #(
  parameter int SPEED_WIDTH = ddrmp_pkg::SPEED_WIDTH_DEF,
  parameter int FRAC_BITS   = ddrmp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  ddrmp_pkg::drive_item_t            cmd,
  output logic                              pkt_valid,
  input  logic                              pkt_ready,
  output ddrmp_pkg::motor_packet_t          pkt,
  input  logic                              cfg_write,
  input  logic [ddrmp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ddrmp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int TGT_W     = ddrmp_pkg::TGT_W;
  localparam int LIMIT_W   = ddrmp_pkg::LIMIT_W;
  localparam int SCALE_W   = ddrmp_pkg::SCALE_W;
  localparam int DATA_W    = ddrmp_pkg::DATA_W;
  localparam int WIDE_FRAC = (FRAC_BITS > LIMIT_W) ? FRAC_BITS : LIMIT_W;
  // Mix magnitude, signed mix, and |w| * half_track widths
  localparam int MAG_W     = SPEED_WIDTH + WIDE_FRAC;
  localparam int MIX_W     = MAG_W + 1;
  localparam int WP_W      = SPEED_WIDTH + LIMIT_W;
  localparam int PROD_W    = MAG_W + SCALE_W;
  localparam int SHIFT     = 2 * FRAC_BITS + 8;
  localparam int EXT_W     = (PROD_W > SHIFT + 8) ? PROD_W : SHIFT + 8;
  localparam int RAMP_W    = ((SPEED_WIDTH > TGT_W) ? SPEED_WIDTH : TGT_W) + 2;

  localparam logic signed [RAMP_W-1:0] SPD_HI =
    {{(RAMP_W - SPEED_WIDTH + 1){1'b0}}, {(SPEED_WIDTH - 1){1'b1}}};
  localparam logic signed [RAMP_W-1:0] SPD_LO = ~SPD_HI;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAMP,
    S_WSTART,
    S_WWAIT,
    S_WTERM,
    S_MIX,
    S_ABS,
    S_SWAIT,
    S_CMD,
    S_EMIT_GO,
    S_EMIT
  } state_t;

  // Symmetric clamp of a target to plus or minus a limit
  function automatic logic signed [TGT_W:0] clamp_sym(
    input logic signed [TGT_W:0] v,
    input logic [LIMIT_W-1:0]    lim
  );
    logic signed [TGT_W:0] l;
    l = $signed({{(TGT_W + 1 - LIMIT_W){1'b0}}, lim});
    if (v > l) begin
      clamp_sym = l;
    end else if (v < -l) begin
      clamp_sym = -l;
    end else begin
      clamp_sym = v;
    end
  endfunction

  // Step the stored speed toward the target, then saturate to the width
  function automatic logic signed [SPEED_WIDTH-1:0] ramp_to(
    input logic signed [SPEED_WIDTH-1:0] cur,
    input logic signed [TGT_W:0]         tgt,
    input logic [LIMIT_W-1:0]            step
  );
    logic signed [RAMP_W-1:0] c;
    logic signed [RAMP_W-1:0] t;
    logic signed [RAMP_W-1:0] s;
    logic signed [RAMP_W-1:0] d;
    logic signed [RAMP_W-1:0] r;
    c = RAMP_W'(cur);
    t = RAMP_W'(tgt);
    s = $signed({{(RAMP_W - LIMIT_W){1'b0}}, step});
    d = t - c;
    r = t;
    if (d > s) begin
      r = c + s;
    end else if (d < -s) begin
      r = c - s;
    end
    if (r > SPD_HI) begin
      r = SPD_HI;
    end else if (r < SPD_LO) begin
      r = SPD_LO;
    end
    ramp_to = r[SPEED_WIDTH-1:0];
  endfunction

  // Scale product to a 7-bit magnitude, saturating at full scale
  function automatic logic [DATA_W-1:0] to_mag(input logic [PROD_W-1:0] p);
    logic [EXT_W-1:0] q;
    q = EXT_W'(p) >> SHIFT;
    if (|q[EXT_W-1:DATA_W]) begin
      to_mag = ddrmp_pkg::DATA_MAX;
    end else begin
      to_mag = q[DATA_W-1:0];
    end
  endfunction

  // Configuration registers
  logic [LIMIT_W-1:0]           max_linear;
  logic [LIMIT_W-1:0]           max_angular;
  logic [LIMIT_W-1:0]           ramp_step;
  logic [LIMIT_W-1:0]           half_track;
  logic [SCALE_W-1:0]           speed_scale;
  logic [ddrmp_pkg::ADDR_W-1:0] front_address;
  logic [ddrmp_pkg::ADDR_W-1:0] rear_address;

  state_t                        state;
  logic signed [SPEED_WIDTH-1:0] linear_speed;
  logic signed [SPEED_WIDTH-1:0] angular_speed;
  logic signed [TGT_W:0]         tgt_linear;
  logic signed [TGT_W:0]         tgt_angular;
  logic signed [MIX_W-1:0]       wterm;
  logic signed [MIX_W-1:0]       mix_l;
  logic signed [MIX_W-1:0]       mix_r;
  ddrmp_pkg::motor_cmd_t         cmd_l;
  ddrmp_pkg::motor_cmd_t         cmd_r;

  logic signed [TGT_W:0]         tl_clamped;
  logic signed [TGT_W:0]         ta_clamped;
  logic [SPEED_WIDTH-1:0]        w_abs;
  logic signed [MIX_W-1:0]       vfull;
  logic [MAG_W-1:0]              abs_l;
  logic [MAG_W-1:0]              abs_r;
  logic [DATA_W-1:0]             mag_l;
  logic [DATA_W-1:0]             mag_r;

  logic                          w_start;
  logic                          w_busy;
  logic [WP_W-1:0]               w_prod;
  logic                          s_start;
  logic                          s_busy_l;
  logic                          s_busy_r;
  logic [PROD_W-1:0]             prod_l;
  logic [PROD_W-1:0]             prod_r;
  logic                          emit_start;
  logic                          emit_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear    <= ddrmp_pkg::MAX_LINEAR_RST;
      max_angular   <= ddrmp_pkg::MAX_ANGULAR_RST;
      ramp_step     <= ddrmp_pkg::RAMP_STEP_RST;
      half_track    <= ddrmp_pkg::HALF_TRACK_RST;
      speed_scale   <= ddrmp_pkg::SPEED_SCALE_RST;
      front_address <= ddrmp_pkg::FRONT_ADDRESS_RST;
      rear_address  <= ddrmp_pkg::REAR_ADDRESS_RST;
    end else if (cfg_write) begin
      case (ddrmp_pkg::reg_index_t'(cfg_index))
        ddrmp_pkg::REG_MAX_LINEAR:    max_linear    <= cfg_data[LIMIT_W-1:0];
        ddrmp_pkg::REG_MAX_ANGULAR:   max_angular   <= cfg_data[LIMIT_W-1:0];
        ddrmp_pkg::REG_RAMP_STEP:     ramp_step     <= cfg_data[LIMIT_W-1:0];
        ddrmp_pkg::REG_HALF_TRACK:    half_track    <= cfg_data[LIMIT_W-1:0];
        ddrmp_pkg::REG_SPEED_SCALE:   speed_scale   <= cfg_data[SCALE_W-1:0];
        ddrmp_pkg::REG_FRONT_ADDRESS: front_address <= cfg_data[ddrmp_pkg::ADDR_W-1:0];
        ddrmp_pkg::REG_REAR_ADDRESS:  rear_address  <= cfg_data[ddrmp_pkg::ADDR_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Datapath helpers between the stages
  always_comb begin
    tl_clamped = clamp_sym({cmd.linear_setpoint[TGT_W-1], cmd.linear_setpoint},
                           max_linear);
    ta_clamped = clamp_sym({cmd.angular_setpoint[TGT_W-1], cmd.angular_setpoint},
                           max_angular);
    w_abs      = angular_speed[SPEED_WIDTH-1] ? SPEED_WIDTH'(-angular_speed)
                                              : SPEED_WIDTH'(angular_speed);
    // v scaled up to the mix fraction: v * 2^FRAC_BITS
    vfull      = $signed({{(MIX_W - SPEED_WIDTH - FRAC_BITS){linear_speed[SPEED_WIDTH-1]}},
                           linear_speed, {FRAC_BITS{1'b0}}});
    abs_l      = mix_l[MIX_W-1] ? MAG_W'(-mix_l) : MAG_W'(mix_l);
    abs_r      = mix_r[MIX_W-1] ? MAG_W'(-mix_r) : MAG_W'(mix_r);
    mag_l      = to_mag(prod_l);
    mag_r      = to_mag(prod_r);
  end

  assign cmd_ready  = (state == S_IDLE);
  assign w_start    = (state == S_WSTART);
  assign s_start    = (state == S_ABS);
  assign emit_start = (state == S_EMIT_GO);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      linear_speed  <= '0;
      angular_speed <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.func == ddrmp_pkg::FUNC_STOP) begin
              // Stop: clear the speeds and send zero commands
              linear_speed  <= '0;
              angular_speed <= '0;
              cmd_l         <= '0;
              cmd_r         <= '0;
              state         <= S_EMIT_GO;
            end else begin
              tgt_linear  <= tl_clamped;
              tgt_angular <= ta_clamped;
              state       <= S_RAMP;
            end
          end
        end
        S_RAMP: begin
          linear_speed  <= ramp_to(linear_speed, tgt_linear, ramp_step);
          angular_speed <= ramp_to(angular_speed, tgt_angular, ramp_step);
          state         <= S_WSTART;
        end
        S_WSTART: begin
          state <= S_WWAIT;
        end
        S_WWAIT: begin
          if (!w_busy) begin
            state <= S_WTERM;
          end
        end
        S_WTERM: begin
          // Reapply the sign of w to |w| * half_track
          if (angular_speed[SPEED_WIDTH-1]) begin
            wterm <= -$signed({{(MIX_W - WP_W){1'b0}}, w_prod});
          end else begin
            wterm <= $signed({{(MIX_W - WP_W){1'b0}}, w_prod});
          end
          state <= S_MIX;
        end
        S_MIX: begin
          mix_l <= vfull - wterm;
          mix_r <= vfull + wterm;
          state <= S_ABS;
        end
        S_ABS: begin
          state <= S_SWAIT;
        end
        S_SWAIT: begin
          if (!s_busy_l && !s_busy_r) begin
            state <= S_CMD;
          end
        end
        S_CMD: begin
          // Zero magnitude always goes out with the forward code
          cmd_l.mag  <= mag_l;
          cmd_l.back <= mix_l[MIX_W-1] && (mag_l != '0);
          cmd_r.mag  <= mag_r;
          cmd_r.back <= mix_r[MIX_W-1] && (mag_r != '0);
          state      <= S_EMIT_GO;
        end
        S_EMIT_GO: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // |w| * half_track, one half_track bit a cycle
  ddrmp_serial_mult #(
    .A_W (SPEED_WIDTH),
    .B_W (LIMIT_W)
  ) u_wmult (
    .clk          (clk),
    .rst          (rst),
    .start        (w_start),
    .multiplicand (w_abs),
    .multiplier   (half_track),
    .busy         (w_busy),
    .product      (w_prod)
  );

  // |mix| * speed_scale for each side, one mix bit a cycle
  ddrmp_serial_mult #(
    .A_W (SCALE_W),
    .B_W (MAG_W)
  ) u_smult_l (
    .clk          (clk),
    .rst          (rst),
    .start        (s_start),
    .multiplicand (speed_scale),
    .multiplier   (abs_l),
    .busy         (s_busy_l),
    .product      (prod_l)
  );

  ddrmp_serial_mult #(
    .A_W (SCALE_W),
    .B_W (MAG_W)
  ) u_smult_r (
    .clk          (clk),
    .rst          (rst),
    .start        (s_start),
    .multiplicand (speed_scale),
    .multiplier   (abs_r),
    .busy         (s_busy_r),
    .product      (prod_r)
  );

  ddrmp_pkt_out u_pkt_out (
    .clk           (clk),
    .rst           (rst),
    .start         (emit_start),
    .left          (cmd_l),
    .right         (cmd_r),
    .front_address (front_address),
    .rear_address  (rear_address),
    .busy          (emit_busy),
    .pkt_valid     (pkt_valid),
    .pkt_ready     (pkt_ready),
    .pkt           (pkt)
  );

endmodule
